// ===== design/ipv4_prefix_trie_lpm_unit_assert.svh =====
// Assertion macros for the IPv4 prefix trie lookup unit.
`ifndef IPV4_PREFIX_TRIE_LPM_UNIT_ASSERT_SVH
`define IPV4_PREFIX_TRIE_LPM_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LPM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpm: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define LPM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpm: next-cycle check failed");

`endif

// ===== design/lpm_pkg.sv =====
// Types, constants and helper functions of the IPv4 prefix trie lookup unit.
package lpm_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int PTR_W      = $clog2(NODE_COUNT);
    localparam int IDX_W      = $clog2(NODE_COUNT + 1);
    localparam int MAX_DEPTH  = 33;
    localparam int DEPTH_W    = $clog2(MAX_DEPTH);
    localparam int ADDR_W     = 32;
    localparam int LEN_W      = 6;

    localparam logic [IDX_W-1:0] NIL     = IDX_W'(NODE_COUNT);
    localparam logic [IDX_W-1:0] POOL_SZ = IDX_W'(NODE_COUNT);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(ADDR_W);

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_DEL   = 2'd1,
        MODE_CHECK = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  len;
        logic              mark;
        logic [IDX_W-1:0]  kid1;
        logic [IDX_W-1:0]  kid0;
    } node_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             dir;
    } path_t;

    function automatic logic [ADDR_W-1:0] mask_of(input logic [LEN_W-1:0] len);
        if (len >= LEN_MAX)
            return '1;
        return ~({ADDR_W{1'b1}} >> len);
    endfunction

    // bit i counted from the MSB; zero past the end
    function automatic logic bit_of(input logic [ADDR_W-1:0] x, input logic [LEN_W-1:0] i);
        if (i >= LEN_MAX)
            return 1'b0;
        return x[5'd31 - i[4:0]];
    endfunction

    function automatic logic is_node(input logic [IDX_W-1:0] i);
        return i < POOL_SZ;
    endfunction

    function automatic node_t mk_node(input logic [ADDR_W-1:0] prefix,
                                      input logic [LEN_W-1:0] len, input logic mark);
        node_t n;
        n.prefix = prefix & mask_of(len);
        n.len    = len;
        n.mark   = mark;
        n.kid1   = NIL;
        n.kid0   = NIL;
        return n;
    endfunction

    function automatic node_t set_kid(input node_t n, input logic dir,
                                      input logic [IDX_W-1:0] idx);
        node_t r;
        r = n;
        if (dir)
            r.kid1 = idx;
        else
            r.kid0 = idx;
        return r;
    endfunction

    // leading zeros of a nibble (nonzero input)
    function automatic logic [1:0] nib_lz(input logic [3:0] v);
        logic [1:0] r;
        priority casez (v)
            4'b1???: r = 2'd0;
            4'b01??: r = 2'd1;
            4'b001?: r = 2'd2;
            default: r = 2'd3;
        endcase
        return r;
    endfunction

endpackage

// ===== design/ipv4_prefix_trie_lpm_unit.sv =====
// Top level of the IPv4 prefix trie lookup unit: sequencer, node pool and free stack.
//
// Longest-prefix-match store for IPv4 held as a path-compressed binary trie
// in a pool of 1024 nodes, handed out from a free-index stack. Each request
// is add (mode 0), delete (1), check (2) or clear (3) and produces exactly one
// result. Add/delete reject a length above 32 or a base with host bits set;
// add also rejects when the pool runs dry. The unit handles one request at a
// time: in_stall stays high from acceptance until the result has been loaded
// into the output register, which can hold a finished result while the next
// request is taken. Run time is set by the node memory, which has one read
// port and one write port and is read once per trie level: check and
// clear-free paths walk down the levels; add walks down, allocates nodes and
// runs a 4-bits-per-cycle prefix compare; delete walks down and then back up
// while merging. There is no clearing pass after reset; the free stack
// tracks its low-water mark so that never-written entries read as their
// reset contents.
module ipv4_prefix_trie_lpm_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  mode,
    input  logic [lpm_pkg::ADDR_W-1:0]  address,
    input  logic [lpm_pkg::LEN_W-1:0]   prefix_len,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        status,
    output logic                        match_found,
    output logic [lpm_pkg::LEN_W-1:0]   match_len
);
    import lpm_pkg::*;

    typedef enum logic [22:0] {
        S_IDLE   = 23'h000001,
        S_GRAB   = 23'h000002,
        S_GRAB_W = 23'h000004,
        S_A_ROOT = 23'h000008,
        S_A_LD   = 23'h000010,
        S_A_N    = 23'h000020,
        S_A_C    = 23'h000040,
        S_A_LINK = 23'h000080,
        S_CLZ    = 23'h000100,
        S_A_SPL1 = 23'h000200,
        S_A_SPL2 = 23'h000400,
        S_A_SPL3 = 23'h000800,
        S_K_R    = 23'h001000,
        S_K_N    = 23'h002000,
        S_K_C    = 23'h004000,
        S_D_R    = 23'h008000,
        S_D_N    = 23'h010000,
        S_D_C    = 23'h020000,
        S_D_SQ   = 23'h040000,
        S_D_PATH = 23'h080000,
        S_D_PAR  = 23'h100000,
        S_D_ROOT = 23'h200000,
        S_DONE   = 23'h400000
    } state_t;

    // ---------------- memories ----------------
    node_t            node_mem [NODE_COUNT];
    logic [PTR_W-1:0] fl_mem   [NODE_COUNT];
    path_t            path_mem [MAX_DEPTH];

    logic             nd_we;
    logic [PTR_W-1:0] nd_waddr, nd_raddr;
    node_t            nd_wdata, nd_rdata;

    logic             fl_we;
    logic [PTR_W-1:0] fl_waddr, fl_raddr, fl_wdata, fl_rdata;

    logic               path_we;
    logic [DEPTH_W-1:0] path_waddr, path_raddr;
    path_t              path_wdata, path_rdata;

    always_ff @(posedge clk)
    begin
        if (nd_we)
            node_mem[nd_waddr] <= nd_wdata;
        nd_rdata <= node_mem[nd_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (fl_we)
            fl_mem[fl_waddr] <= fl_wdata;
        fl_rdata <= fl_mem[fl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (path_we)
            path_mem[path_waddr] <= path_wdata;
        path_rdata <= path_mem[path_raddr];
    end

    // ---------------- control registers ----------------
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] root_reg, root_next;
    logic [IDX_W-1:0] fc_reg, fc_next;         // free count
    logic [IDX_W-1:0] min_fc_reg, min_fc_next; // stack entries below this never written
    logic             out_valid_reg, out_valid_next;

    // ---------------- working registers ----------------
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    node_t              cur_reg, cur_next;
    logic [IDX_W-1:0]   cur_idx_reg, cur_idx_next;
    node_t              chd_reg, chd_next;
    logic [IDX_W-1:0]   chd_idx_reg, chd_idx_next;
    logic               dir_reg, dir_next;
    logic               pdir_reg, pdir_next;
    node_t              g_node_reg, g_node_next;
    state_t             g_ret_reg, g_ret_next;
    logic               g_ok_reg, g_ok_next;
    logic [IDX_W-1:0]   g_idx_reg, g_idx_next;
    logic               g_low_reg, g_low_next;
    node_t              mid_reg, mid_next;
    logic [IDX_W-1:0]   mid_idx_reg, mid_idx_next;
    logic [ADDR_W-1:0]  clz_x_reg, clz_x_next;
    logic [LEN_W-1:0]   clz_n_reg, clz_n_next;
    logic [DEPTH_W-1:0] d_reg, d_next;
    logic [IDX_W-1:0]   sq_reg, sq_next;
    logic               best_vld_reg, best_vld_next;
    logic [LEN_W-1:0]   best_len_reg, best_len_next;
    logic               res_status_reg, res_status_next;
    logic               res_found_reg, res_found_next;
    logic [LEN_W-1:0]   res_len_reg, res_len_next;
    logic               status_reg, status_next;
    logic               found_reg, found_next;
    logic [LEN_W-1:0]   mlen_reg, mlen_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            root_reg      <= NIL;
            fc_reg        <= POOL_SZ;
            min_fc_reg    <= POOL_SZ;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            root_reg      <= root_next;
            fc_reg        <= fc_next;
            min_fc_reg    <= min_fc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg       <= base_next;
        len_reg        <= len_next;
        cur_reg        <= cur_next;
        cur_idx_reg    <= cur_idx_next;
        chd_reg        <= chd_next;
        chd_idx_reg    <= chd_idx_next;
        dir_reg        <= dir_next;
        pdir_reg       <= pdir_next;
        g_node_reg     <= g_node_next;
        g_ret_reg      <= g_ret_next;
        g_ok_reg       <= g_ok_next;
        g_idx_reg      <= g_idx_next;
        g_low_reg      <= g_low_next;
        mid_reg        <= mid_next;
        mid_idx_reg    <= mid_idx_next;
        clz_x_reg      <= clz_x_next;
        clz_n_reg      <= clz_n_next;
        d_reg          <= d_next;
        sq_reg         <= sq_next;
        best_vld_reg   <= best_vld_next;
        best_len_reg   <= best_len_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_len_reg    <= res_len_next;
        status_reg     <= status_next;
        found_reg      <= found_next;
        mlen_reg       <= mlen_next;
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        node_t             n_c;
        node_t             tmp;
        logic [ADDR_W-1:0] x;
        logic              dir;
        logic [IDX_W-1:0]  c;
        logic [LEN_W-1:0]  need;
        logic [LEN_W-1:0]  l;
        logic              bad;
        logic [PTR_W-1:0]  got;

        state_next      = state_reg;
        root_next       = root_reg;
        fc_next         = fc_reg;
        min_fc_next     = min_fc_reg;
        base_next       = base_reg;
        len_next        = len_reg;
        cur_next        = cur_reg;
        cur_idx_next    = cur_idx_reg;
        chd_next        = chd_reg;
        chd_idx_next    = chd_idx_reg;
        dir_next        = dir_reg;
        pdir_next       = pdir_reg;
        g_node_next     = g_node_reg;
        g_ret_next      = g_ret_reg;
        g_ok_next       = g_ok_reg;
        g_idx_next      = g_idx_reg;
        g_low_next      = g_low_reg;
        mid_next        = mid_reg;
        mid_idx_next    = mid_idx_reg;
        clz_x_next      = clz_x_reg;
        clz_n_next      = clz_n_reg;
        d_next          = d_reg;
        sq_next         = sq_reg;
        best_vld_next   = best_vld_reg;
        best_len_next   = best_len_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_len_next    = res_len_reg;
        status_next     = status_reg;
        found_next      = found_reg;
        mlen_next       = mlen_reg;
        out_valid_next  = out_valid_reg && out_stall;

        nd_we      = 1'b0;
        nd_waddr   = cur_idx_reg[PTR_W-1:0];
        nd_wdata   = cur_reg;
        nd_raddr   = cur_idx_reg[PTR_W-1:0];
        fl_we      = 1'b0;
        fl_waddr   = fc_reg[PTR_W-1:0];
        fl_wdata   = cur_idx_reg[PTR_W-1:0];
        fl_raddr   = fc_reg[PTR_W-1:0];
        path_we    = 1'b0;
        path_waddr = d_reg;
        path_wdata = '{idx: cur_idx_reg, dir: dir_reg};
        path_raddr = d_reg;

        n_c  = nd_rdata;
        tmp  = cur_reg;
        x    = base_reg ^ nd_rdata.prefix;
        dir  = bit_of(base_reg, cur_reg.len);
        c    = dir ? cur_reg.kid1 : cur_reg.kid0;
        need = (len_reg < nd_rdata.len) ? len_reg : nd_rdata.len;
        l    = clz_n_reg + {4'd0, nib_lz(clz_x_reg[31:28])};
        bad  = (prefix_len > LEN_MAX) || ((address & ~mask_of(prefix_len)) != '0);
        got  = g_low_reg ? PTR_W'(POOL_SZ - fc_reg) : fl_rdata;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    base_next       = address;
                    len_next        = prefix_len;
                    res_status_next = 1'b0;
                    res_found_next  = 1'b0;
                    res_len_next    = '0;
                    cur_idx_next    = root_reg;
                    nd_raddr        = root_reg[PTR_W-1:0];
                    unique case (mode_t'(mode))
                        MODE_ADD:
                        begin
                            if (bad)
                            begin
                                res_status_next = 1'b1;
                                state_next      = S_DONE;
                            end
                            else if (!is_node(root_reg))
                            begin
                                g_node_next = mk_node('0, '0, 1'b0);
                                g_ret_next  = S_A_ROOT;
                                state_next  = S_GRAB;
                            end
                            else
                                state_next = S_A_LD;
                        end
                        MODE_DEL:
                        begin
                            if (bad)
                            begin
                                res_status_next = 1'b1;
                                state_next      = S_DONE;
                            end
                            else if (!is_node(root_reg))
                                state_next = S_DONE;
                            else
                                state_next = S_D_R;
                        end
                        MODE_CHECK:
                        begin
                            if (!is_node(root_reg))
                                state_next = S_DONE;
                            else
                                state_next = S_K_R;
                        end
                        MODE_CLEAR:
                        begin
                            root_next   = NIL;
                            fc_next     = POOL_SZ;
                            min_fc_next = POOL_SZ;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end

            // pop one index off the free stack and write g_node there; fail if it is empty
            S_GRAB:
            begin
                if (fc_reg == '0)
                begin
                    g_ok_next  = 1'b0;
                    state_next = g_ret_reg;
                end
                else
                begin
                    fl_raddr   = PTR_W'(fc_reg - IDX_W'(1));
                    g_low_next = (fc_reg - IDX_W'(1)) < min_fc_reg;
                    state_next = S_GRAB_W;
                end
            end

            S_GRAB_W:
            begin
                nd_we      = 1'b1;
                nd_waddr   = got;
                nd_wdata   = g_node_reg;
                g_idx_next = {1'b0, got};
                g_ok_next  = 1'b1;
                fc_next    = fc_reg - IDX_W'(1);
                if (g_low_reg)
                    min_fc_next = fc_reg - IDX_W'(1);
                state_next = g_ret_reg;
            end

            // ---------------- add ----------------
            S_A_ROOT:
            begin
                if (!g_ok_reg)
                begin
                    res_status_next = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    root_next    = g_idx_reg;
                    cur_idx_next = g_idx_reg;
                    nd_raddr     = g_idx_reg[PTR_W-1:0];
                    state_next   = S_A_LD;
                end
            end

            S_A_LD:
            begin
                cur_next   = nd_rdata;
                state_next = S_A_N;
            end

            S_A_N:
            begin
                if (cur_reg.len == len_reg)
                begin
                    tmp.mark   = 1'b1;
                    nd_we      = 1'b1;
                    nd_wdata   = tmp;
                    state_next = S_DONE;
                end
                else
                begin
                    dir_next = dir;
                    if (!is_node(c))
                    begin
                        g_node_next = mk_node(base_reg, len_reg, 1'b1);
                        g_ret_next  = S_A_LINK;
                        state_next  = S_GRAB;
                    end
                    else
                    begin
                        chd_idx_next = c;
                        nd_raddr     = c[PTR_W-1:0];
                        state_next   = S_A_C;
                    end
                end
            end

            S_A_C:
            begin
                if (len_reg <= n_c.len && (x & mask_of(len_reg)) == '0)
                begin
                    if (len_reg == n_c.len)
                    begin
                        n_c.mark   = 1'b1;
                        nd_we      = 1'b1;
                        nd_waddr   = chd_idx_reg[PTR_W-1:0];
                        nd_wdata   = n_c;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        g_node_next = set_kid(mk_node(base_reg, len_reg, 1'b1),
                                              bit_of(nd_rdata.prefix, len_reg), chd_idx_reg);
                        g_ret_next  = S_A_LINK;
                        state_next  = S_GRAB;
                    end
                end
                else if ((x & mask_of(n_c.len)) == '0 && n_c.len < len_reg)
                begin
                    cur_next     = n_c;
                    cur_idx_next = chd_idx_reg;
                    state_next   = S_A_N;
                end
                else
                begin
                    chd_next   = n_c;
                    clz_x_next = x;
                    clz_n_next = '0;
                    state_next = S_CLZ;
                end
            end

            // hang the newly grabbed node under cur
            S_A_LINK:
            begin
                if (!g_ok_reg)
                    res_status_next = 1'b1;
                else
                begin
                    nd_we    = 1'b1;
                    nd_wdata = set_kid(cur_reg, dir_reg, g_idx_reg);
                end
                state_next = S_DONE;
            end

            // common prefix length, one nibble per cycle
            S_CLZ:
            begin
                if (clz_x_reg[31:28] != 4'd0 || clz_n_reg == LEN_W'(28))
                begin
                    if (clz_x_reg[31:28] == 4'd0)
                        l = LEN_MAX;
                    clz_n_next  = l;
                    g_node_next = set_kid(mk_node(base_reg, l, 1'b0),
                                          bit_of(chd_reg.prefix, l), chd_idx_reg);
                    g_ret_next  = S_A_SPL1;
                    state_next  = S_GRAB;
                end
                else
                begin
                    clz_x_next = clz_x_reg << 4;
                    clz_n_next = clz_n_reg + LEN_W'(4);
                end
            end

            S_A_SPL1:
            begin
                if (!g_ok_reg)
                begin
                    res_status_next = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    mid_idx_next = g_idx_reg;
                    mid_next     = g_node_reg;
                    g_node_next  = mk_node(base_reg, len_reg, 1'b1);
                    g_ret_next   = S_A_SPL2;
                    state_next   = S_GRAB;
                end
            end

            S_A_SPL2:
            begin
                if (!g_ok_reg)
                begin
                    // give the split node back
                    if (fc_reg < POOL_SZ)
                    begin
                        fl_we    = 1'b1;
                        fl_wdata = mid_idx_reg[PTR_W-1:0];
                        fc_next  = fc_reg + IDX_W'(1);
                    end
                    res_status_next = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    nd_we      = 1'b1;
                    nd_waddr   = mid_idx_reg[PTR_W-1:0];
                    nd_wdata   = set_kid(mid_reg, bit_of(base_reg, clz_n_reg), g_idx_reg);
                    state_next = S_A_SPL3;
                end
            end

            S_A_SPL3:
            begin
                nd_we      = 1'b1;
                nd_wdata   = set_kid(cur_reg, dir_reg, mid_idx_reg);
                state_next = S_DONE;
            end

            // ---------------- check ----------------
            S_K_R:
            begin
                cur_next      = nd_rdata;
                best_vld_next = nd_rdata.mark;
                best_len_next = '0;
                state_next    = S_K_N;
            end

            S_K_N:
            begin
                if (cur_reg.len >= LEN_MAX || !is_node(c))
                begin
                    res_found_next = best_vld_reg;
                    res_len_next   = best_len_reg;
                    state_next     = S_DONE;
                end
                else
                begin
                    nd_raddr   = c[PTR_W-1:0];
                    state_next = S_K_C;
                end
            end

            S_K_C:
            begin
                if ((base_reg & mask_of(n_c.len)) != n_c.prefix)
                begin
                    res_found_next = best_vld_reg;
                    res_len_next   = best_len_reg;
                    state_next     = S_DONE;
                end
                else
                begin
                    cur_next = n_c;
                    if (n_c.mark)
                    begin
                        best_vld_next = 1'b1;
                        best_len_next = n_c.len;
                    end
                    state_next = S_K_N;
                end
            end

            // ---------------- delete ----------------
            S_D_R:
            begin
                cur_next   = nd_rdata;
                d_next     = '0;
                path_we    = 1'b1;
                path_waddr = '0;
                path_wdata = '{idx: cur_idx_reg, dir: 1'b0};
                if (len_reg == '0)
                begin
                    n_c.mark = 1'b0;
                    nd_we    = 1'b1;
                    nd_wdata = n_c;
                    if (!is_node(n_c.kid0) && !is_node(n_c.kid1))
                    begin
                        if (fc_reg < POOL_SZ)
                        begin
                            fl_we   = 1'b1;
                            fc_next = fc_reg + IDX_W'(1);
                        end
                        root_next = NIL;
                    end
                    state_next = S_DONE;
                end
                else
                    state_next = S_D_N;
            end

            S_D_N:
            begin
                if (cur_reg.len < len_reg && d_reg < DEPTH_W'(MAX_DEPTH - 1))
                begin
                    if (!is_node(c))
                        state_next = S_DONE;
                    else
                    begin
                        dir_next     = dir;
                        chd_idx_next = c;
                        nd_raddr     = c[PTR_W-1:0];
                        state_next   = S_D_C;
                    end
                end
                else if (cur_reg.len != len_reg || !cur_reg.mark)
                    state_next = S_DONE;
                else
                begin
                    tmp.mark   = 1'b0;
                    cur_next   = tmp;
                    nd_we      = 1'b1;
                    nd_wdata   = tmp;
                    state_next = (d_reg == '0) ? S_D_ROOT : S_D_SQ;
                end
            end

            S_D_C:
            begin
                if ((x & mask_of(need)) != '0)
                    state_next = S_DONE;
                else
                begin
                    cur_next     = n_c;
                    cur_idx_next = chd_idx_reg;
                    d_next       = d_reg + DEPTH_W'(1);
                    path_we      = 1'b1;
                    path_waddr   = d_reg + DEPTH_W'(1);
                    path_wdata   = '{idx: chd_idx_reg, dir: dir_reg};
                    state_next   = S_D_N;
                end
            end

            // collapse cur if it is unmarked with fewer than two children
            S_D_SQ:
            begin
                path_raddr = d_reg - DEPTH_W'(1);
                if (cur_reg.mark || (is_node(cur_reg.kid0) && is_node(cur_reg.kid1)))
                    sq_next = cur_idx_reg;
                else
                begin
                    if (is_node(cur_reg.kid1))
                        sq_next = cur_reg.kid1;
                    else
                        sq_next = cur_reg.kid0;
                    if (fc_reg < POOL_SZ)
                    begin
                        fl_we   = 1'b1;
                        fc_next = fc_reg + IDX_W'(1);
                    end
                end
                state_next = S_D_PATH;
            end

            S_D_PATH:
            begin
                cur_idx_next = path_rdata.idx;
                pdir_next    = path_rdata.dir;
                nd_raddr     = path_rdata.idx[PTR_W-1:0];
                state_next   = S_D_PAR;
            end

            S_D_PAR:
            begin
                tmp        = set_kid(nd_rdata, dir_reg, sq_reg);
                cur_next   = tmp;
                nd_we      = 1'b1;
                nd_wdata   = tmp;
                dir_next   = pdir_reg;
                d_next     = d_reg - DEPTH_W'(1);
                state_next = (d_reg == DEPTH_W'(1)) ? S_D_ROOT : S_D_SQ;
            end

            S_D_ROOT:
            begin
                if (!cur_reg.mark && !is_node(cur_reg.kid0) && !is_node(cur_reg.kid1))
                begin
                    if (fc_reg < POOL_SZ)
                    begin
                        fl_we    = 1'b1;
                        fl_wdata = root_reg[PTR_W-1:0];
                        fc_next  = fc_reg + IDX_W'(1);
                    end
                    root_next = NIL;
                end
                state_next = S_DONE;
            end

            // hand the result to the output register once it is free
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    found_next     = res_found_reg;
                    mlen_next      = res_len_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign match_found = found_reg;
    assign match_len   = mlen_reg;

    // ---------------- assertions ----------------
`include "ipv4_prefix_trie_lpm_unit_assert.svh"

    `LPM_ASSERT_IMP(a_low_water, 1'b1, min_fc_reg <= fc_reg && fc_reg <= POOL_SZ)
    `LPM_ASSERT_NXT(a_busy_after_req, in_valid && !in_stall, in_stall)
    `LPM_ASSERT_IMP(a_check_ok, out_valid && match_found, status == 1'b0)
    `LPM_ASSERT_IMP(a_no_len_wo_match, out_valid && !match_found, match_len == '0)

endmodule
